>>> rtl/huff_pkg.sv
package huff_pkg;

  localparam int unsigned SYMBOLS    = 128;
  localparam int unsigned COUNT_BITS = 24;
  localparam int unsigned NODES      = 2 * SYMBOLS - 1;
  localparam int unsigned INT_NODES  = SYMBOLS - 1;
  localparam int unsigned SYM_W      = $clog2(SYMBOLS);
  localparam int unsigned NODE_W     = $clog2(NODES);
  localparam int unsigned INT_W      = $clog2(INT_NODES);
  localparam int unsigned WEIGHT_W   = 32;
  localparam int unsigned LEN_W      = 8;
  localparam int unsigned CHUNK_W    = 32;
  localparam int unsigned CHUNKS     = 4;
  localparam int unsigned CODE_BITS  = CHUNK_W * CHUNKS;

  typedef enum logic [1:0] {
    ACT_COUNT  = 2'd0,
    ACT_BUILD  = 2'd1,
    ACT_ENCODE = 2'd2,
    ACT_DECODE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_ACK    = 2'd0,
    KIND_CHUNK  = 2'd1,
    KIND_SYMBOL = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_NO_CODE = 2'd1,
    ERR_NO_TREE = 2'd2
  } err_e;

  typedef enum logic [2:0] {
    EMIT_ACK     = 3'd0,
    EMIT_NO_CODE = 3'd1,
    EMIT_NO_TREE = 3'd2,
    EMIT_CHUNK   = 3'd3,
    EMIT_DECODE  = 3'd4
  } emit_e;

  typedef struct packed {
    action_e    action;
    logic [6:0] symbol;
    logic       code_bit;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [6:0]  out_symbol;
    logic [31:0] code_chunk;
    logic [5:0]  chunk_length;
    logic        last;
    err_e        error_code;
  } out_item_t;

  typedef struct packed {
    logic  accept;
    logic  cnt_wr;
    logic  init_start;
    logic  init_rd;
    logic  init_wr;
    logic  empty_fin;
    logic  lone_fin;
    logic  scan_start;
    logic  scan_step;
    logic  mrg1;
    logic  mrg2;
    logic  walk_start;
    logic  walk_load;
    logic  walk_step;
    logic  walk_wr;
    logic  walk_next;
    logic  tree_fin;
    logic  emit;
    emit_e emit_sel;
  } cmd_t;

  typedef struct packed {
    logic tree_ready;
    logic slot_free;
    logic init_last;
    logic leaves_zero;
    logic leaves_one;
    logic scan_last;
    logic merge_last;
    logic walk_leaf;
    logic walk_last;
    logic walk_at_root;
    logic enc_no_code;
    logic chunk_last;
  } sts_t;

endpackage

>>> rtl/huff_ctrl.sv
module huff_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  huff_pkg::action_e in_action_i,
  output logic              in_stall_o,
  input  huff_pkg::sts_t    sts_i,
  output huff_pkg::cmd_t    cmd_o
);

  typedef enum logic [21:0] {
    S_IDLE     = 22'h000001,
    S_CNT_RD   = 22'h000002,
    S_CNT_WR   = 22'h000004,
    S_ACK      = 22'h000008,
    S_NOTREE   = 22'h000010,
    S_ENC_RD   = 22'h000020,
    S_ENC_OUT  = 22'h000040,
    S_DEC_RD   = 22'h000080,
    S_DEC_OUT  = 22'h000100,
    S_B_IRD    = 22'h000200,
    S_B_IWR    = 22'h000400,
    S_B_DECIDE = 22'h000800,
    S_B_SCAN   = 22'h001000,
    S_B_SCEND  = 22'h002000,
    S_B_MRG1   = 22'h004000,
    S_B_MRG2   = 22'h008000,
    S_W_SEL    = 22'h010000,
    S_W_RD     = 22'h020000,
    S_W_STEP   = 22'h040000,
    S_W_WR     = 22'h080000,
    S_B_DONE   = 22'h100000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.emit_sel = huff_pkg::EMIT_ACK;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          case (in_action_i)
            huff_pkg::ACT_COUNT: state_d = S_CNT_RD;
            huff_pkg::ACT_BUILD: begin
              cmd_o.init_start = 1'b1;
              state_d = S_B_IRD;
            end
            huff_pkg::ACT_ENCODE: state_d = sts_i.tree_ready ? S_ENC_RD : S_NOTREE;
            huff_pkg::ACT_DECODE: state_d = sts_i.tree_ready ? S_DEC_RD : S_NOTREE;
            default: state_d = S_NOTREE;
          endcase
        end
      end
      S_CNT_RD: state_d = S_CNT_WR;
      S_CNT_WR: begin
        cmd_o.cnt_wr = 1'b1;
        state_d = S_ACK;
      end
      S_ACK: begin
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.emit_sel = huff_pkg::EMIT_ACK;
          state_d = S_IDLE;
        end
      end
      S_NOTREE: begin
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.emit_sel = huff_pkg::EMIT_NO_TREE;
          state_d = S_IDLE;
        end
      end
      S_ENC_RD: state_d = S_ENC_OUT;
      S_ENC_OUT: begin
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.emit_sel = sts_i.enc_no_code ? huff_pkg::EMIT_NO_CODE : huff_pkg::EMIT_CHUNK;
          if (sts_i.enc_no_code || sts_i.chunk_last) state_d = S_IDLE;
        end
      end
      S_DEC_RD: state_d = S_DEC_OUT;
      S_DEC_OUT: begin
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.emit_sel = huff_pkg::EMIT_DECODE;
          state_d = S_IDLE;
        end
      end
      S_B_IRD: begin
        cmd_o.init_rd = 1'b1;
        state_d = S_B_IWR;
      end
      S_B_IWR: begin
        cmd_o.init_wr = 1'b1;
        state_d = sts_i.init_last ? S_B_DECIDE : S_B_IRD;
      end
      S_B_DECIDE: begin
        if (sts_i.leaves_zero) begin
          cmd_o.empty_fin = 1'b1;
          state_d = S_ACK;
        end else if (sts_i.leaves_one) begin
          cmd_o.lone_fin = 1'b1;
          state_d = S_ACK;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d = S_B_SCAN;
        end
      end
      S_B_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) state_d = S_B_SCEND;
      end
      S_B_SCEND: state_d = S_B_MRG1;
      S_B_MRG1: begin
        cmd_o.mrg1 = 1'b1;
        state_d = S_B_MRG2;
      end
      S_B_MRG2: begin
        cmd_o.mrg2 = 1'b1;
        if (sts_i.merge_last) begin
          cmd_o.walk_start = 1'b1;
          state_d = S_W_SEL;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d = S_B_SCAN;
        end
      end
      S_W_SEL: begin
        if (sts_i.walk_leaf) begin
          cmd_o.walk_load = 1'b1;
          state_d = S_W_RD;
        end else if (sts_i.walk_last) begin
          state_d = S_B_DONE;
        end else begin
          cmd_o.walk_next = 1'b1;
        end
      end
      S_W_RD: state_d = S_W_STEP;
      S_W_STEP: begin
        cmd_o.walk_step = 1'b1;
        state_d = sts_i.walk_at_root ? S_W_WR : S_W_RD;
      end
      S_W_WR: begin
        cmd_o.walk_wr = 1'b1;
        if (sts_i.walk_last) begin
          state_d = S_B_DONE;
        end else begin
          cmd_o.walk_next = 1'b1;
          state_d = S_W_SEL;
        end
      end
      S_B_DONE: begin
        cmd_o.tree_fin = 1'b1;
        state_d = S_ACK;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/huff_dp.sv
module huff_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  huff_pkg::in_item_t  in_data_i,
  input  huff_pkg::cmd_t      cmd_i,
  output huff_pkg::sts_t      sts_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output huff_pkg::out_item_t out_data_o
);

  localparam int unsigned SW = huff_pkg::SYM_W;
  localparam int unsigned NW = huff_pkg::NODE_W;
  localparam int unsigned WW = huff_pkg::WEIGHT_W;
  localparam int unsigned CB = huff_pkg::COUNT_BITS;

  huff_pkg::in_item_t item_q;

  // histogram
  logic [CB-1:0]                cnt_mem [huff_pkg::SYMBOLS];
  logic [huff_pkg::SYMBOLS-1:0] cnt_vld_q;
  logic [CB-1:0]                cnt_rd_q;
  logic                         cnt_vld_rd_q;
  logic [SW-1:0]                cnt_addr;
  logic [CB-1:0]                cnt_val, cnt_inc;

  // tree build
  logic [WW-1:0]                 wt_mem [huff_pkg::NODES];
  logic [WW-1:0]                 wt_rd_q;
  logic [2*NW-1:0]               ch_mem [huff_pkg::INT_NODES];
  logic [2*NW-1:0]               ch_rd_q;
  logic [NW:0]                   up_mem [huff_pkg::NODES];
  logic [NW:0]                   up_rd_q;
  logic [huff_pkg::NODES-1:0]    live_q;
  logic [huff_pkg::SYMBOLS-1:0]  leaf_q;
  logic [SW-1:0]                 s_q, lone_q;
  logic [SW:0]                   leaves_q;
  logic [huff_pkg::INT_W-1:0]    made_q;
  logic [NW-1:0]                 j_q, cmp_idx_q, p_node;
  logic                          cmp_v_q;
  logic [WW-1:0]                 min1_w_q, min2_w_q;
  logic [NW-1:0]                 min1_i_q, min2_i_q;
  logic                          min1_v_q, min2_v_q;
  logic [WW:0]                   wsum;
  logic [WW-1:0]                 wsat;

  // code walk
  logic [NW-1:0]                  n_q;
  logic [huff_pkg::CODE_BITS-1:0] code_q;
  logic [SW-1:0]                  depth_q;

  // code table
  logic [huff_pkg::LEN_W-1:0]     len_mem  [huff_pkg::SYMBOLS];
  logic [huff_pkg::CODE_BITS-1:0] word_mem [huff_pkg::SYMBOLS];
  logic [huff_pkg::SYMBOLS-1:0]   cl_vld_q;
  logic [huff_pkg::LEN_W-1:0]     len_rd_q;
  logic [huff_pkg::CODE_BITS-1:0] word_rd_q;
  logic                           cl_vld_rd_q;
  logic                           tbl_we;
  logic [SW-1:0]                  tbl_addr;
  logic [huff_pkg::LEN_W-1:0]     enc_len, rem;
  logic [1:0]                     chunk_q;
  logic [5:0]                     chunk_n;

  // decoder
  logic                 tree_ready_q;
  logic [NW-1:0]        root_q, dpos_q, dec_next;
  logic [SW-1:0]        ch_ix;

  // result register
  logic                 out_valid_q;
  huff_pkg::out_item_t  out_q, out_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) item_q <= in_data_i;
  end

  // histogram: read at one address, write back the saturated increment
  assign cnt_addr = cmd_i.init_rd ? s_q : item_q.symbol;
  assign cnt_val  = cnt_vld_rd_q ? cnt_rd_q : '0;
  assign cnt_inc  = (cnt_val == '1) ? cnt_val : cnt_val + 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cnt_wr) cnt_mem[item_q.symbol] <= cnt_inc;
    cnt_rd_q <= cnt_mem[cnt_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q    <= '0;
      cnt_vld_rd_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_wr) cnt_vld_q[item_q.symbol] <= 1'b1;
      cnt_vld_rd_q <= cnt_vld_q[cnt_addr];
    end
  end

  // node weights
  assign p_node = NW'(huff_pkg::SYMBOLS) + NW'(made_q);
  assign wsum   = {1'b0, min1_w_q} + {1'b0, min2_w_q};
  assign wsat   = wsum[WW] ? '1 : wsum[WW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_wr) begin
      wt_mem[NW'(s_q)] <= WW'(cnt_val);
    end else if (cmd_i.mrg1) begin
      wt_mem[p_node] <= wsat;
    end
    wt_rd_q <= wt_mem[j_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mrg1) ch_mem[made_q] <= {min2_i_q, min1_i_q};
    ch_rd_q <= ch_mem[ch_ix];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mrg1) begin
      up_mem[min1_i_q] <= {p_node, 1'b0};
    end else if (cmd_i.mrg2) begin
      up_mem[min2_i_q] <= {p_node, 1'b1};
    end
    up_rd_q <= up_mem[n_q];
  end

  // build control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q    <= '0;
      leaf_q    <= '0;
      s_q       <= '0;
      lone_q    <= '0;
      leaves_q  <= '0;
      made_q    <= '0;
      j_q       <= '0;
      cmp_idx_q <= '0;
      cmp_v_q   <= 1'b0;
      min1_v_q  <= 1'b0;
      min2_v_q  <= 1'b0;
    end else begin
      cmp_v_q <= 1'b0;
      if (cmd_i.init_start) begin
        live_q   <= '0;
        leaf_q   <= '0;
        s_q      <= '0;
        leaves_q <= '0;
        made_q   <= '0;
      end
      if (cmd_i.init_wr) begin
        s_q <= s_q + 1'b1;
        if (cnt_val != '0) begin
          live_q[NW'(s_q)] <= 1'b1;
          leaf_q[s_q]      <= 1'b1;
          leaves_q         <= leaves_q + 1'b1;
          lone_q           <= s_q;
        end
      end
      if (cmd_i.scan_start) begin
        j_q      <= '0;
        min1_v_q <= 1'b0;
        min2_v_q <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        j_q       <= j_q + 1'b1;
        cmp_v_q   <= 1'b1;
        cmp_idx_q <= j_q;
      end
      // ascending scan with strict compares keeps the lower index on a tie
      if (cmp_v_q && live_q[cmp_idx_q]) begin
        if (!min1_v_q || wt_rd_q < min1_w_q) begin
          min2_v_q <= min1_v_q;
          min1_v_q <= 1'b1;
        end else if (!min2_v_q || wt_rd_q < min2_w_q) begin
          min2_v_q <= 1'b1;
        end
      end
      if (cmd_i.mrg1) begin
        live_q[min1_i_q] <= 1'b0;
        live_q[min2_i_q] <= 1'b0;
        live_q[p_node]   <= 1'b1;
      end
      if (cmd_i.mrg2) made_q <= made_q + 1'b1;
      if (cmd_i.walk_start) s_q <= '0;
      if (cmd_i.walk_next) s_q <= s_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmp_v_q && live_q[cmp_idx_q]) begin
      if (!min1_v_q || wt_rd_q < min1_w_q) begin
        min2_w_q <= min1_w_q;
        min2_i_q <= min1_i_q;
        min1_w_q <= wt_rd_q;
        min1_i_q <= cmp_idx_q;
      end else if (!min2_v_q || wt_rd_q < min2_w_q) begin
        min2_w_q <= wt_rd_q;
        min2_i_q <= cmp_idx_q;
      end
    end
  end

  // walk from a leaf up to the root, shifting in the branch side
  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_load) begin
      n_q     <= NW'(s_q);
      code_q  <= '0;
      depth_q <= '0;
    end else if (cmd_i.walk_step) begin
      n_q     <= up_rd_q[NW:1];
      code_q  <= {code_q[huff_pkg::CODE_BITS-2:0], up_rd_q[0]};
      depth_q <= depth_q + 1'b1;
    end
  end

  // code table
  assign tbl_we   = cmd_i.lone_fin || cmd_i.walk_wr;
  assign tbl_addr = cmd_i.lone_fin ? lone_q : s_q;

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      len_mem[tbl_addr]  <= cmd_i.lone_fin ? huff_pkg::LEN_W'(1)
                                           : huff_pkg::LEN_W'(depth_q);
      word_mem[tbl_addr] <= cmd_i.lone_fin ? '0 : code_q;
    end
    len_rd_q  <= len_mem[item_q.symbol];
    word_rd_q <= word_mem[item_q.symbol];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cl_vld_q    <= '0;
      cl_vld_rd_q <= 1'b0;
    end else begin
      if (cmd_i.init_start) begin
        cl_vld_q <= '0;
      end else if (tbl_we) begin
        cl_vld_q[tbl_addr] <= 1'b1;
      end
      cl_vld_rd_q <= cl_vld_q[item_q.symbol];
    end
  end

  assign enc_len = cl_vld_rd_q ? len_rd_q : '0;
  assign rem     = enc_len - {1'b0, chunk_q, 5'b0};
  assign chunk_n = (rem <= huff_pkg::LEN_W'(huff_pkg::CHUNK_W)) ? rem[5:0] : 6'd32;

  // decoder position and tree state
  assign ch_ix    = (dpos_q[SW-1:0] == SW'(huff_pkg::INT_NODES)) ?
                    SW'(huff_pkg::INT_NODES - 1) : dpos_q[SW-1:0];
  assign dec_next = item_q.code_bit ? ch_rd_q[2*NW-1:NW] : ch_rd_q[NW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tree_ready_q <= 1'b0;
      root_q       <= '0;
      dpos_q       <= '0;
      chunk_q      <= '0;
    end else begin
      if (cmd_i.accept) chunk_q <= '0;
      if (cmd_i.emit && cmd_i.emit_sel == huff_pkg::EMIT_CHUNK) chunk_q <= chunk_q + 1'b1;
      if (cmd_i.empty_fin) begin
        tree_ready_q <= 1'b0;
        root_q       <= '0;
        dpos_q       <= '0;
      end
      if (cmd_i.lone_fin) begin
        tree_ready_q <= 1'b1;
        root_q       <= NW'(lone_q);
        dpos_q       <= NW'(lone_q);
      end
      if (cmd_i.mrg2 && sts_o.merge_last) root_q <= p_node;
      if (cmd_i.tree_fin) begin
        tree_ready_q <= 1'b1;
        dpos_q       <= root_q;
      end
      if (cmd_i.emit && cmd_i.emit_sel == huff_pkg::EMIT_DECODE &&
          dpos_q >= NW'(huff_pkg::SYMBOLS)) begin
        if (dec_next < NW'(huff_pkg::SYMBOLS) || dec_next == '1) begin
          dpos_q <= root_q;
        end else begin
          dpos_q <= dec_next;
        end
      end
    end
  end

  // result register
  always_comb begin
    out_d = '0;
    out_d.kind = huff_pkg::KIND_ACK;
    out_d.error_code = huff_pkg::ERR_NONE;
    out_d.last = 1'b1;
    case (cmd_i.emit_sel)
      huff_pkg::EMIT_ACK: ;
      huff_pkg::EMIT_NO_CODE: begin
        out_d.kind = huff_pkg::KIND_ERROR;
        out_d.error_code = huff_pkg::ERR_NO_CODE;
      end
      huff_pkg::EMIT_NO_TREE: begin
        out_d.kind = huff_pkg::KIND_ERROR;
        out_d.error_code = huff_pkg::ERR_NO_TREE;
      end
      huff_pkg::EMIT_CHUNK: begin
        out_d.kind = huff_pkg::KIND_CHUNK;
        out_d.code_chunk = word_rd_q[{chunk_q, 5'b0} +: huff_pkg::CHUNK_W];
        out_d.chunk_length = chunk_n;
        out_d.last = sts_o.chunk_last;
      end
      huff_pkg::EMIT_DECODE: begin
        if (dpos_q < NW'(huff_pkg::SYMBOLS)) begin
          out_d.kind = huff_pkg::KIND_SYMBOL;
          out_d.out_symbol = dpos_q[SW-1:0];
        end else if (dec_next < NW'(huff_pkg::SYMBOLS)) begin
          out_d.kind = huff_pkg::KIND_SYMBOL;
          out_d.out_symbol = dec_next[SW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    sts_o.tree_ready   = tree_ready_q;
    sts_o.slot_free    = !out_valid_q || !out_stall_i;
    sts_o.init_last    = (s_q == SW'(huff_pkg::SYMBOLS - 1));
    sts_o.leaves_zero  = (leaves_q == '0);
    sts_o.leaves_one   = (leaves_q == (SW+1)'(1));
    sts_o.scan_last    = (j_q == NW'(huff_pkg::NODES - 1));
    sts_o.merge_last   = ({1'b0, made_q} == leaves_q - (SW+1)'(2));
    sts_o.walk_leaf    = leaf_q[s_q];
    sts_o.walk_last    = (s_q == SW'(huff_pkg::SYMBOLS - 1));
    sts_o.walk_at_root = (up_rd_q[NW:1] == root_q);
    sts_o.enc_no_code  = (enc_len == '0);
    sts_o.chunk_last   = (rem <= huff_pkg::LEN_W'(huff_pkg::CHUNK_W));
  end

endmodule

>>> rtl/huffman_codec_top.sv
// Channel   Direction  Valid        Stall        Payload
// request   in         in_valid_i   in_stall_o   in_data_i  (huff_pkg::in_item_t)
// result    out        out_valid_o  out_stall_i  out_data_o (huff_pkg::out_item_t)
//
// One request at a time. A count reads and increments its symbol's histogram entry;
// decode emits one result and encode one result per chunk. Build sweeps the histogram,
// scans all 255 node weights once per merge and walks every leaf to the root, with
// absent symbols skipped.
// Reset clears histogram and code-length valid bits at once; no clearing pass.
// A stalled result holds; a request is taken while the last result still waits.
module huffman_codec_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  huff_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output huff_pkg::out_item_t out_data_o
);

  huff_pkg::cmd_t cmd;
  huff_pkg::sts_t sts;

  huff_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_data_i.action),
    .in_stall_o  (in_stall_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  huff_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while idle did not stall the next one");

  a_chunks_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last |=> out_valid_o)
    else $error("code chunk stream broken before its last chunk");

  a_chunk_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == huff_pkg::KIND_CHUNK |->
      out_data_o.chunk_length != 6'd0 && out_data_o.error_code == huff_pkg::ERR_NONE)
    else $error("malformed code chunk");

  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.slot_free)
    else $error("result written over a pending one");
`endif

endmodule
